### design/wnm_pkg.sv
// shared constants, types and helpers for the wildcard name matcher
package wnm_pkg;

   // pattern storage and configuration widths
   localparam int CHAR_SLOTS          = 16;
   localparam int PATTERN_MAX_DEFAULT = 16;
   localparam int CSR_DATA_W          = 64;
   localparam int CSR_INDEX_W         = 2;
   localparam int LEN_REG_W           = 5;
   localparam int FIFO_DEPTH          = 2;

   // special pattern characters and case folding
   localparam logic [7:0] STAR_CHAR   = 8'h2A;
   localparam logic [7:0] QMARK_CHAR  = 8'h3F;
   localparam logic [7:0] UPPER_A     = 8'h41;
   localparam logic [7:0] UPPER_Z     = 8'h5A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   // register reset values: the pattern is a single star
   localparam logic [CSR_DATA_W-1:0] PAT_LOW_RESET  = 64'h0000_0000_0000_002A;
   localparam logic [CSR_DATA_W-1:0] PAT_HIGH_RESET = 64'h0000_0000_0000_0000;
   localparam logic [LEN_REG_W-1:0]  PAT_LEN_RESET  = 5'd1;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PAT_LOW  = 2'd0,
      CSR_PAT_HIGH = 2'd1,
      CSR_PAT_LEN  = 2'd2
   } csr_index_type;

   // configured pattern as seen by the datapath
   typedef struct packed {
      logic [CHAR_SLOTS-1:0][7:0] chars;
      logic [LEN_REG_W-1:0]       length;
   } pattern_type;

   // classified request passed from front to back
   typedef struct packed {
      logic [CHAR_SLOTS-1:0] hit;
      logic                  last;
   } class_type;

   // fold ascii upper case to lower case
   function automatic logic [7:0] fold_char(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= UPPER_A && c <= UPPER_Z) begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

endpackage

### design/wnm_if.sv
// request and response channel interfaces of the wildcard name matcher
interface wnm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] name_char;
   logic       name_last;

   modport source(output valid, output name_char, output name_last, input ready);
   modport sink(input valid, input name_char, input name_last, output ready);
endinterface

interface wnm_rsp_if;
   logic valid;
   logic ready;
   logic prefix_matches;
   logic name_done;

   modport source(output valid, output prefix_matches, output name_done, input ready);
   modport sink(input valid, input prefix_matches, input name_done, output ready);
endinterface

### design/wnm_csr.sv
// pattern configuration registers of the wildcard name matcher
module wnm_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [wnm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [wnm_pkg::CSR_DATA_W-1:0]     csr_write_data,
   output wnm_pkg::pattern_type               pattern,
   output logic                               restart
);
   import wnm_pkg::*;

   logic [CSR_DATA_W-1:0] pat_low_ff;
   logic [CSR_DATA_W-1:0] pat_low_in;
   logic [CSR_DATA_W-1:0] pat_high_ff;
   logic [CSR_DATA_W-1:0] pat_high_in;
   logic [LEN_REG_W-1:0]  pat_len_ff;
   logic [LEN_REG_W-1:0]  pat_len_in;

   // register write decode
   always_comb begin
      pat_low_in  = pat_low_ff;
      pat_high_in = pat_high_ff;
      pat_len_in  = pat_len_ff;
      restart     = 1'b0;
      case (csr_index_type'(csr_index))
         CSR_PAT_LOW: begin
            if (csr_write_en) begin
               pat_low_in = csr_write_data;
               restart    = 1'b1;
            end
         end
         CSR_PAT_HIGH: begin
            if (csr_write_en) begin
               pat_high_in = csr_write_data;
               restart     = 1'b1;
            end
         end
         CSR_PAT_LEN: begin
            if (csr_write_en) begin
               pat_len_in = csr_write_data[LEN_REG_W-1:0];
               restart    = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= PAT_LOW_RESET;
         pat_high_ff <= PAT_HIGH_RESET;
         pat_len_ff  <= PAT_LEN_RESET;
      end else begin
         pat_low_ff  <= pat_low_in;
         pat_high_ff <= pat_high_in;
         pat_len_ff  <= pat_len_in;
      end
   end

   // character 0 sits in the lowest byte
   assign pattern.chars  = {pat_high_ff, pat_low_ff};
   assign pattern.length = pat_len_ff;

endmodule

### design/wnm_front.sv
// front end: accepts name characters and compares them to every pattern slot
module wnm_front (
   wnm_req_if.sink             req_chan,
   input  wnm_pkg::pattern_type pattern,
   input  logic                 fifo_full,
   output logic                 push,
   output wnm_pkg::class_type   push_entry
);
   import wnm_pkg::*;

   logic [7:0] folded_char;

   // per-slot character compare, case folded, question mark matches anything
   always_comb begin
      folded_char = fold_char(req_chan.name_char);
      for (int i = 0; i < CHAR_SLOTS; i++) begin
         push_entry.hit[i] = (pattern.chars[i] == QMARK_CHAR) ||
                             (fold_char(pattern.chars[i]) == folded_char);
      end
      push_entry.last = req_chan.name_last;
   end

   // request handshake into the queue
   assign req_chan.ready = !fifo_full;
   assign push           = req_chan.valid && !fifo_full;

endmodule

### design/wnm_fifo.sv
// short queue between the classifying front end and the matching back end
module wnm_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  wnm_pkg::class_type  push_entry,
   input  logic                pop,
   output logic                full,
   output logic                out_valid,
   output wnm_pkg::class_type  out_entry
);
   import wnm_pkg::*;

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   class_type          entry_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign full      = (count_ff == CNT_W'(FIFO_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_entry = entry_ff[rd_ptr_ff];

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FIFO_DEPTH))
      else $error("queue occupancy above depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue push without pop did not grow occupancy");
`endif

endmodule

### design/wnm_back.sv
// back end: advances the live pattern positions and registers the response
module wnm_back #(
   parameter int PATTERN_MAX = wnm_pkg::PATTERN_MAX_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  wnm_pkg::pattern_type pattern,
   input  logic                 restart,
   input  logic                 in_valid,
   input  wnm_pkg::class_type   in_entry,
   output logic                 pop,
   wnm_rsp_if.source            rsp_chan
);
   import wnm_pkg::*;

   localparam int POS_COUNT = (PATTERN_MAX < CHAR_SLOTS) ? PATTERN_MAX : CHAR_SLOTS;
   localparam int LEN_W     = $clog2(POS_COUNT + 1);

   logic [POS_COUNT:0]   live_ff;
   logic [POS_COUNT:0]   live_in;
   logic                 fresh_ff;
   logic                 fresh_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 prefix_ff;
   logic                 prefix_in;
   logic                 done_ff;
   logic                 done_in;

   logic [LEN_W-1:0]     eff_len;
   logic [POS_COUNT-1:0] active;
   logic [POS_COUNT-1:0] star_act;
   logic [POS_COUNT:0]   start_vec;
   logic [POS_COUNT:0]   base_vec;
   logic [POS_COUNT:0]   step_vec;
   logic [POS_COUNT:0]   next_vec;
   logic                 match;

   // a live star position also makes the position after it live
   function automatic logic [POS_COUNT:0] close_stars(input logic [POS_COUNT:0] v,
                                                      input logic [POS_COUNT-1:0] s);
      logic [POS_COUNT:0] r;
      r = v;
      for (int i = 0; i < POS_COUNT; i++) begin
         if (r[i] && s[i]) begin
            r[i+1] = 1'b1;
         end
      end
      return r;
   endfunction

   // effective length and star slots of the pattern
   always_comb begin
      if (int'(pattern.length) > POS_COUNT) begin
         eff_len = LEN_W'(POS_COUNT);
      end else begin
         eff_len = pattern.length[LEN_W-1:0];
      end
      for (int i = 0; i < POS_COUNT; i++) begin
         active[i]   = (LEN_W'(i) < eff_len);
         star_act[i] = active[i] && (pattern.chars[i] == STAR_CHAR);
      end
      start_vec = close_stars({{POS_COUNT{1'b0}}, 1'b1}, star_act);
   end

   // one character step of the position vector
   always_comb begin
      base_vec = fresh_ff ? start_vec : live_ff;
      step_vec = '0;
      for (int i = 0; i < POS_COUNT; i++) begin
         if (base_vec[i] && active[i]) begin
            if (star_act[i]) begin
               step_vec[i] = 1'b1;
            end else if (in_entry.hit[i]) begin
               step_vec[i+1] = 1'b1;
            end
         end
      end
      next_vec = close_stars(step_vec, star_act);
      match    = next_vec[eff_len];
   end

   // pop when the response register is free or being drained
   assign pop = in_valid && (!rsp_valid_ff || rsp_chan.ready);

   // matcher state and response register next values
   always_comb begin
      live_in      = live_ff;
      fresh_in     = fresh_ff;
      prefix_in    = prefix_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (pop) begin
         rsp_valid_in = 1'b1;
         prefix_in    = match;
         done_in      = in_entry.last;
         if (in_entry.last) begin
            fresh_in = 1'b1;
         end else begin
            live_in  = next_vec;
            fresh_in = 1'b0;
         end
      end
      if (restart) begin
         fresh_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      live_ff   <= live_in;
      prefix_ff <= prefix_in;
      done_ff   <= done_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.prefix_matches = prefix_ff;
   assign rsp_chan.name_done      = done_ff;

`ifndef SYNTH
   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      pop && in_entry.last |=> fresh_ff)
      else $error("matcher did not restart after the last character");

   a_cfg_restarts: assert property (@(posedge clock) disable iff (reset)
      restart |=> fresh_ff)
      else $error("matcher did not restart after a register write");

   a_pop_responds: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid_ff && done_ff == $past(in_entry.last))
      else $error("popped request did not produce its response");
`endif

endmodule

### design/wildcard_name_matcher_core.sv
// top level of the wildcard name matcher
//
// Matches a streamed name, one byte per request, against a glob pattern of
// up to 16 characters held in three registers ('?' is any one character,
// '*' any run, letters compare without case). Each request carries
// name_char and name_last; each response carries prefix_matches (the name
// so far matches the whole pattern) and name_done (copy of name_last).
// The csr port writes pattern_chars_low (index 0), pattern_chars_high
// (index 1) and pattern_length (index 2); any such write restarts the
// matcher. Write registers only while no request is in flight.
// The front end's compare result enters the queue at the accepting edge,
// and the position-vector update loads the response register when the
// back end pops that entry from the queue.
// Throughput is one request per cycle unless the response receiver stalls.
// Reset loads the single-star pattern and an empty queue; no clearing pass.
// When the response receiver stalls, the response register holds, the
// two-entry queue fills and req_chan.ready drops once it is full.
module wildcard_name_matcher_core #(
   parameter int PATTERN_MAX = wnm_pkg::PATTERN_MAX_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   wnm_req_if.sink                         req_chan,
   wnm_rsp_if.source                       rsp_chan,
   input  logic                            csr_write_en,
   input  logic [wnm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [wnm_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import wnm_pkg::*;

   pattern_type pattern;
   logic        restart;
   logic        fifo_full;
   logic        push;
   class_type   push_entry;
   logic        pop;
   logic        queue_valid;
   class_type   queue_entry;

   // configuration registers
   wnm_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .pattern        (pattern),
      .restart        (restart)
   );

   // request classification
   wnm_front u_front (
      .req_chan   (req_chan),
      .pattern    (pattern),
      .fifo_full  (fifo_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // decoupling queue
   wnm_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (fifo_full),
      .out_valid  (queue_valid),
      .out_entry  (queue_entry)
   );

   // position vector update and response
   wnm_back #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .pattern  (pattern),
      .restart  (restart),
      .in_valid (queue_valid),
      .in_entry (queue_entry),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

### sim/tb_top.sv
// testbench for the wildcard name matcher core: self-checking, random and directed
`timescale 1ns / 1ps

module tb_top;
   import wnm_pkg::*;

   localparam int PATTERN_MAX   = PATTERN_MAX_DEFAULT;
   localparam int SETTLE_CYCLES = 4;
   localparam int LONG_HOLD     = 50;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic prefix_matches;
      logic name_done;
   } verdict_type;

   logic clock;
   logic reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   wnm_req_if req_if();
   wnm_rsp_if rsp_if();

   wildcard_name_matcher_core #(
      .PATTERN_MAX(PATTERN_MAX)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // predictor state: registers and live pattern positions
   logic [63:0]         pat_low;
   logic [63:0]         pat_high;
   logic [LEN_REG_W-1:0] pat_len;
   logic [16:0]         live_pos;

   verdict_type expected_verdicts[$];
   logic [7:0]  name_bytes[$];

   int error_count    = 0;
   int chars_sent     = 0;
   int names_checked  = 0;
   int matches_seen   = 0;
   int csr_writes     = 0;
   int stall_odds     = 0;
   int long_hold_left = 0;

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // matcher predictor
   // ---------------------------------------------------------------------

   function automatic int unsigned active_length();
      int unsigned cap;
      int unsigned len;
      cap = (PATTERN_MAX < CHAR_SLOTS) ? PATTERN_MAX : CHAR_SLOTS;
      len = 32'(pat_len);
      return (len > cap) ? cap : len;
   endfunction

   function automatic logic [7:0] pattern_byte(int unsigned i);
      return (i < 8) ? pat_low[i*8 +: 8] : pat_high[(i-8)*8 +: 8];
   endfunction

   function automatic logic [7:0] lower_case(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
   endfunction

   // a live star also makes the position after it live
   function automatic logic [16:0] spread_stars(logic [16:0] v);
      int unsigned len;
      len = active_length();
      for (int unsigned i = 0; i < len; i++) begin
         if (v[i] && pattern_byte(i) == STAR_CHAR) begin
            v[i+1] = 1'b1;
         end
      end
      return v;
   endfunction

   // advance the live positions by one name byte and return the verdict
   function automatic verdict_type advance_matcher(logic [7:0] ch, logic last);
      int unsigned len;
      logic [16:0] next;
      logic [7:0]  p;
      verdict_type v;
      len  = active_length();
      next = '0;
      for (int unsigned i = 0; i < len; i++) begin
         if (live_pos[i]) begin
            p = pattern_byte(i);
            if (p == STAR_CHAR) begin
               next[i] = 1'b1;
            end else if (p == QMARK_CHAR || lower_case(p) == lower_case(ch)) begin
               next[i+1] = 1'b1;
            end
         end
      end
      next = spread_stars(next);
      v.prefix_matches = next[len];
      v.name_done      = last;
      live_pos = last ? spread_stars(17'd1) : next;
      return v;
   endfunction

   // ---------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, logic [63:0] data);
      @(negedge clock);
      csr_write_en   = 1'b1;
      csr_index      = idx;
      csr_write_data = data;
      @(negedge clock);
      csr_write_en   = 1'b0;
      csr_write_data = {$urandom, $urandom};
      csr_writes++;
      case (idx)
         CSR_PAT_LOW:  pat_low  = data;
         CSR_PAT_HIGH: pat_high = data;
         CSR_PAT_LEN:  pat_len  = data[LEN_REG_W-1:0];
         default:      return;
      endcase
      live_pos = spread_stars(17'd1);
   endtask

   // one request; valid stays high after acceptance until the next call
   task automatic send_request(logic [7:0] ch, logic last);
      @(negedge clock);
      req_if.valid     = 1'b1;
      req_if.name_char = ch;
      req_if.name_last = last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      expected_verdicts.push_back(advance_matcher(ch, last));
      chars_sent++;
   endtask

   // random gap with valid low
   task automatic sender_pause();
      int n;
      if (stall_odds != 0 && $urandom_range(1, 12) <= stall_odds) begin
         n = $urandom_range(1, 9);
         @(negedge clock);
         req_if.valid     = 1'b0;
         req_if.name_char = 8'($urandom);
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // drop valid and wait until every request has its response
   task automatic settle_matcher();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_name(string s);
      for (int i = 0; i < s.len(); i++) begin
         send_request(s[i], i == s.len() - 1);
      end
   endtask

   function automatic logic [63:0] pattern_word(string s, int first);
      logic [63:0] w;
      w = '0;
      for (int b = 0; b < 8; b++) begin
         if (first + b < s.len()) w[b*8 +: 8] = s[first + b];
      end
      return w;
   endfunction

   task automatic load_pattern(string s);
      write_register(CSR_PAT_LOW, pattern_word(s, 0));
      write_register(CSR_PAT_HIGH, pattern_word(s, 8));
      write_register(CSR_PAT_LEN, 64'(s.len()));
   endtask

   // ---------------------------------------------------------------------
   // random content
   // ---------------------------------------------------------------------

   function automatic logic [7:0] random_name_char();
      case ($urandom_range(0, 4))
         0:       return "a";
         1:       return "b";
         2:       return "A";
         3:       return "B";
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] random_pattern_char();
      case ($urandom_range(0, 7))
         0, 1:    return STAR_CHAR;
         2:       return QMARK_CHAR;
         3:       return "a";
         4:       return "B";
         5:       return "b";
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] flip_case(logic [7:0] c);
      if (c >= "A" && c <= "Z") return c + 8'h20;
      if (c >= "a" && c <= "z") return c - 8'h20;
      return c;
   endfunction

   task automatic program_random_pattern();
      logic [63:0] words [2];
      int unsigned len;
      for (int w = 0; w < 2; w++) begin
         for (int b = 0; b < 8; b++) words[w][b*8 +: 8] = random_pattern_char();
         if ($urandom_range(0, 7) == 0) words[w] = {$urandom, $urandom};
      end
      case ($urandom_range(0, 9))
         0:       len = 0;
         1:       len = $urandom_range(17, 31);
         2, 3:    len = $urandom_range(9, 16);
         default: len = $urandom_range(1, 8);
      endcase
      write_register(CSR_PAT_LOW, words[0]);
      write_register(CSR_PAT_HIGH, words[1]);
      write_register(CSR_PAT_LEN, {$urandom, 27'($urandom), len[LEN_REG_W-1:0]});
   endtask

   // mostly names built to follow the pattern, some pure noise
   task automatic build_name();
      int unsigned len;
      logic [7:0]  p;
      name_bytes.delete();
      if ($urandom_range(0, 9) < 7) begin
         len = active_length();
         for (int unsigned i = 0; i < len; i++) begin
            p = pattern_byte(i);
            if (p == STAR_CHAR) begin
               repeat ($urandom_range(0, 3)) name_bytes.push_back(random_name_char());
            end else if (p == QMARK_CHAR) begin
               name_bytes.push_back(random_name_char());
            end else begin
               name_bytes.push_back($urandom_range(0, 1) ? flip_case(p) : p);
            end
         end
         if (name_bytes.size() != 0 && $urandom_range(0, 4) == 0) begin
            name_bytes[$urandom_range(0, name_bytes.size() - 1)] = random_name_char();
         end
         if ($urandom_range(0, 5) == 0) name_bytes.push_back(random_name_char());
      end else begin
         repeat ($urandom_range(1, 12)) name_bytes.push_back(random_name_char());
      end
      if (name_bytes.size() == 0) name_bytes.push_back(random_name_char());
   endtask

   // a cut-short name never sets name_last
   task automatic send_random_name(bit cut_short);
      int n;
      build_name();
      n = name_bytes.size();
      if (cut_short) n = $urandom_range(1, n);
      for (int i = 0; i < n; i++) begin
         sender_pause();
         send_request(name_bytes[i], !cut_short && i == n - 1);
      end
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // single star after reset matches everything, zero and 0xff bytes too
   task automatic test_reset_pattern();
      send_request("Q", 1'b1);
      send_request(8'h00, 1'b0);
      send_request(8'hFF, 1'b1);
      settle_matcher();
   endtask

   // case folding, question mark, zero bytes and exact high bytes
   task automatic test_case_and_bytes();
      load_pattern("Ab?d");
      send_name("aBxD");
      settle_matcher();
      write_register(CSR_PAT_LOW, {40'h0, "x", 8'h00, 8'hC1});
      write_register(CSR_PAT_LEN, 64'd3);
      send_request(8'hE1, 1'b0);
      send_request(8'h00, 1'b0);
      send_request("X", 1'b1);
      send_request(8'hC1, 1'b0);
      send_request(8'h00, 1'b0);
      send_request("X", 1'b1);
      settle_matcher();
   endtask

   // consecutive stars and a question mark right after a star
   task automatic test_star_runs();
      load_pattern("a**?");
      send_name("A");
      send_name("ab");
      settle_matcher();
   endtask

   // empty pattern, then an oversized length that saturates at 16
   task automatic test_length_extremes();
      write_register(CSR_PAT_LEN, 64'd0);
      send_name("a");
      settle_matcher();
      write_register(CSR_PAT_LOW, {8{STAR_CHAR}});
      write_register(CSR_PAT_HIGH, {"z", {7{STAR_CHAR}}});
      write_register(CSR_PAT_LEN, '1);
      send_name("Z");
      settle_matcher();
   endtask

   // a register write drops the name in progress, an unused index does not
   task automatic test_restart_on_write();
      load_pattern("ab");
      send_request("a", 1'b0);
      settle_matcher();
      write_register(CSR_PAT_LOW, pattern_word("ab", 0));
      send_request("b", 1'b1);
      send_request("a", 1'b0);
      settle_matcher();
      write_register(CSR_UNUSED, {$urandom, $urandom});
      send_request("b", 1'b1);
      settle_matcher();
   endtask

   // long receiver hold while requests keep coming, so the input stalls
   task automatic test_backpressure();
      load_pattern("*a?");
      stall_odds     = 0;
      long_hold_left = LONG_HOLD;
      repeat (4) send_name("bAx");
      settle_matcher();
   endtask

   task automatic test_random_names(int n_items);
      int target;
      target = chars_sent + n_items;
      while (chars_sent < target) begin
         settle_matcher();
         program_random_pattern();
         stall_odds = $urandom_range(0, 3);
         repeat ($urandom_range(2, 15)) send_random_name(1'b0);
         if ($urandom_range(0, 3) == 0) send_random_name(1'b1);
      end
      settle_matcher();
   endtask

   // no idling on either side for the closing stretch
   task automatic test_full_rate(int n_items);
      int target;
      target     = chars_sent + n_items;
      stall_odds = 0;
      program_random_pattern();
      while (chars_sent < target) send_random_name(1'b0);
      settle_matcher();
   endtask

   // ---------------------------------------------------------------------
   // response side
   // ---------------------------------------------------------------------

   // receiver ready with random stall bursts and an optional long hold
   initial begin : drive_rsp_ready
      int stall_left;
      stall_left    = 0;
      rsp_if.ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_left > 0) begin
            rsp_if.ready = 1'b0;
            long_hold_left--;
         end else if (stall_left > 0) begin
            rsp_if.ready = 1'b0;
            stall_left--;
         end else if (stall_odds != 0 && $urandom_range(1, 16) <= stall_odds) begin
            rsp_if.ready = 1'b0;
            stall_left   = $urandom_range(0, 8);
         end else begin
            rsp_if.ready = 1'b1;
         end
      end
   end

   // compare each response with the oldest predicted verdict
   always @(posedge clock) begin : check_responses
      verdict_type got;
      verdict_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.prefix_matches = rsp_if.prefix_matches;
         got.name_done      = rsp_if.name_done;
         if (expected_verdicts.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = expected_verdicts.pop_front();
            if (got.prefix_matches !== want.prefix_matches) begin
               report_mismatch($sformatf("prefix_matches %b, predicted %b",
                                         got.prefix_matches, want.prefix_matches));
            end
            if (got.name_done !== want.name_done) begin
               report_mismatch($sformatf("name_done %b, predicted %b",
                                         got.name_done, want.name_done));
            end
            if (want.name_done) names_checked++;
            if (want.name_done && want.prefix_matches) matches_seen++;
         end
      end
   end

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      csr_write_en     = 1'b0;
      csr_index        = CSR_PAT_LOW;
      csr_write_data   = '0;
      req_if.valid     = 1'b0;
      req_if.name_char = '0;
      req_if.name_last = 1'b0;
      pat_low          = PAT_LOW_RESET;
      pat_high         = PAT_HIGH_RESET;
      pat_len          = PAT_LEN_RESET;
      live_pos         = spread_stars(17'd1);
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_pattern();
      test_case_and_bytes();
      test_star_runs();
      test_length_extremes();
      test_restart_on_write();
      test_backpressure();
      test_random_names(1050);
      test_full_rate(150);

      $display("covered %0d name bytes in %0d finished names, %0d full matches",
               chars_sent, names_checked, matches_seen);
      $display("with %0d register writes and %0d mismatches", csr_writes, error_count);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // hang guard
   initial begin
      #400000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
